// ===== rtl/vmbr_pkg.sv =====
// Package of types, register offsets and identity constants for the virtio-mmio block registers.
package vmbr_pkg;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_DONE  = 2'd2
  } action_e;

  localparam int unsigned ActionW   = 2;
  localparam int unsigned OffsetW   = 12;
  localparam int unsigned SizeW     = 4;
  localparam int unsigned WordW     = 32;
  localparam int unsigned CapW      = 64;
  localparam int unsigned InDataW   = 48;
  localparam int unsigned OutDataW  = 40;

  localparam logic [WordW-1:0] ID_MAGIC      = 32'h7472_6976;
  localparam logic [WordW-1:0] ID_VENDOR     = 32'h4348_4950;
  localparam logic [WordW-1:0] ID_VERSION    = 32'd2;
  localparam logic [WordW-1:0] ID_DEVICE     = 32'd2;
  localparam logic [WordW-1:0] FEATURES_LOW  = 32'h0000_0240;
  localparam logic [WordW-1:0] FEATURES_HIGH = 32'd1;
  localparam logic [WordW-1:0] QUEUE_MAX     = 32'd256;
  localparam logic [WordW-1:0] SECTOR_BYTES  = 32'd512;

  localparam logic [OffsetW-1:0] OFF_MAGIC       = 12'h000;
  localparam logic [OffsetW-1:0] OFF_VERSION     = 12'h004;
  localparam logic [OffsetW-1:0] OFF_DEVICE_ID   = 12'h008;
  localparam logic [OffsetW-1:0] OFF_VENDOR      = 12'h00c;
  localparam logic [OffsetW-1:0] OFF_DEV_FEAT    = 12'h010;
  localparam logic [OffsetW-1:0] OFF_DEV_FEAT_SEL = 12'h014;
  localparam logic [OffsetW-1:0] OFF_DRV_FEAT    = 12'h020;
  localparam logic [OffsetW-1:0] OFF_DRV_FEAT_SEL = 12'h024;
  localparam logic [OffsetW-1:0] OFF_QUEUE_IDX   = 12'h030;
  localparam logic [OffsetW-1:0] OFF_QUEUE_MAX   = 12'h034;
  localparam logic [OffsetW-1:0] OFF_QUEUE_SIZE  = 12'h038;
  localparam logic [OffsetW-1:0] OFF_QUEUE_EN    = 12'h044;
  localparam logic [OffsetW-1:0] OFF_INT_STATUS  = 12'h060;
  localparam logic [OffsetW-1:0] OFF_INT_ACK     = 12'h064;
  localparam logic [OffsetW-1:0] OFF_STATUS      = 12'h070;
  localparam logic [OffsetW-1:0] OFF_DESC_LO     = 12'h080;
  localparam logic [OffsetW-1:0] OFF_DESC_HI     = 12'h084;
  localparam logic [OffsetW-1:0] OFF_AVAIL_LO    = 12'h090;
  localparam logic [OffsetW-1:0] OFF_AVAIL_HI    = 12'h094;
  localparam logic [OffsetW-1:0] OFF_USED_LO     = 12'h0a0;
  localparam logic [OffsetW-1:0] OFF_USED_HI     = 12'h0a4;
  localparam logic [OffsetW-1:0] OFF_CAP_LO      = 12'h100;
  localparam logic [OffsetW-1:0] OFF_CAP_HI      = 12'h104;
  localparam logic [OffsetW-1:0] OFF_BLK_SIZE    = 12'h114;

endpackage

// ===== rtl/virtio_mmio_block_registers_core.sv =====
// Register file of a virtio-mmio block device with a stream request and response channel.
//
// Requests enter on the s_axis channel: tuser carries the action (read, write or
// queue completion), tdata the offset, access size and write data. Every request
// gives exactly one response on the m_axis channel: the read value (zero for
// anything but a read) and the interrupt pending flag after the request.
// The user must load the capacity register via cfg_we_i / cfg_wdata_i only while idle;
// the block does not enforce it. The response is valid in the cycle after acceptance.
// Throughput is one item per cycle unless the receiver stalls; a single response register bounds it.
// The request side stays ready while the response register is empty or is
// being taken in the same cycle; a stalled receiver holds the response and
// stops further requests until it is taken.
// Reset clears all run-time registers and the capacity, sets the queue size to
// its maximum and empties the response register. A status write of zero
// clears the run-time registers again; the capacity is kept.
module virtio_mmio_block_registers_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // offset[11:0], access_size[15:12], write_data[47:16]
  input  logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // read_data[31:0], irq_pending[32], zero[39:33]
);

  localparam int unsigned W = vmbr_pkg::WordW;

  logic [W-1:0]                dev_sel_q, dev_sel_d;
  logic [W-1:0]                drv_sel_q, drv_sel_d;
  logic [W-1:0]                drv_feat_q [2];
  logic [W-1:0]                drv_feat_d [2];
  logic [W-1:0]                vq_idx_q, vq_idx_d;
  logic [W-1:0]                queue_size_q, queue_size_d;
  logic [W-1:0]                vq_en_q, vq_en_d;
  logic [vmbr_pkg::CapW-1:0]   desc_q, desc_d;
  logic [vmbr_pkg::CapW-1:0]   avail_q, avail_d;
  logic [vmbr_pkg::CapW-1:0]   used_q, used_d;
  logic [W-1:0]                status_q, status_d;
  logic [W-1:0]                int_q, int_d;
  logic [vmbr_pkg::CapW-1:0]   cap_q;
  logic [W-1:0]                rdata_q, rdata_d;
  logic                        irq_q;
  logic                        out_valid_q;

  logic                          accept;
  vmbr_pkg::action_e             action;
  logic [vmbr_pkg::OffsetW-1:0]  offset;
  logic [vmbr_pkg::SizeW-1:0]    access_size;
  logic [W-1:0]                  wdata;
  logic                          drv_idx;
  logic [W-1:0]                  raw;

  assign action      = vmbr_pkg::action_e'(s_axis_tuser);
  assign offset      = s_axis_tdata[11:0];
  assign access_size = s_axis_tdata[15:12];
  assign wdata       = s_axis_tdata[47:16];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign drv_idx       = (|drv_sel_q[W-1:1]) | drv_sel_q[0];

  always_comb begin
    case (offset)
      vmbr_pkg::OFF_MAGIC:        raw = vmbr_pkg::ID_MAGIC;
      vmbr_pkg::OFF_VERSION:      raw = vmbr_pkg::ID_VERSION;
      vmbr_pkg::OFF_DEVICE_ID:    raw = vmbr_pkg::ID_DEVICE;
      vmbr_pkg::OFF_VENDOR:       raw = vmbr_pkg::ID_VENDOR;
      vmbr_pkg::OFF_DEV_FEAT: begin
        if (dev_sel_q == '0) begin
          raw = vmbr_pkg::FEATURES_LOW;
        end else if (dev_sel_q == W'(1)) begin
          raw = vmbr_pkg::FEATURES_HIGH;
        end else begin
          raw = '0;
        end
      end
      vmbr_pkg::OFF_DEV_FEAT_SEL: raw = dev_sel_q;
      vmbr_pkg::OFF_DRV_FEAT:     raw = drv_feat_q[drv_idx];
      vmbr_pkg::OFF_DRV_FEAT_SEL: raw = drv_sel_q;
      vmbr_pkg::OFF_QUEUE_IDX:    raw = vq_idx_q;
      vmbr_pkg::OFF_QUEUE_MAX:    raw = vmbr_pkg::QUEUE_MAX;
      vmbr_pkg::OFF_QUEUE_SIZE:   raw = queue_size_q;
      vmbr_pkg::OFF_QUEUE_EN:     raw = vq_en_q;
      vmbr_pkg::OFF_INT_STATUS:   raw = int_q;
      vmbr_pkg::OFF_STATUS:       raw = status_q;
      vmbr_pkg::OFF_CAP_LO:       raw = cap_q[W-1:0];
      vmbr_pkg::OFF_CAP_HI:       raw = cap_q[vmbr_pkg::CapW-1:W];
      vmbr_pkg::OFF_BLK_SIZE:     raw = vmbr_pkg::SECTOR_BYTES;
      default:                    raw = '0;
    endcase
  end

  always_comb begin
    rdata_d = '0;
    if (action == vmbr_pkg::ACT_READ) begin
      case (access_size)
        4'd1:    rdata_d = {24'd0, raw[7:0]};
        4'd2:    rdata_d = {16'd0, raw[15:0]};
        default: rdata_d = raw;
      endcase
    end
  end

  always_comb begin
    dev_sel_d     = dev_sel_q;
    drv_sel_d     = drv_sel_q;
    drv_feat_d    = drv_feat_q;
    vq_idx_d      = vq_idx_q;
    queue_size_d  = queue_size_q;
    vq_en_d       = vq_en_q;
    desc_d        = desc_q;
    avail_d       = avail_q;
    used_d        = used_q;
    status_d      = status_q;
    int_d         = int_q;
    if (action == vmbr_pkg::ACT_DONE) begin
      int_d = int_q | W'(1);
    end else if (action == vmbr_pkg::ACT_WRITE) begin
      case (offset)
        vmbr_pkg::OFF_DEV_FEAT_SEL: dev_sel_d = wdata;
        vmbr_pkg::OFF_DRV_FEAT:     drv_feat_d[drv_idx] = wdata;
        vmbr_pkg::OFF_DRV_FEAT_SEL: drv_sel_d = wdata;
        vmbr_pkg::OFF_QUEUE_IDX:    vq_idx_d = wdata;
        vmbr_pkg::OFF_QUEUE_SIZE:   queue_size_d = wdata;
        vmbr_pkg::OFF_QUEUE_EN:     vq_en_d = wdata;
        vmbr_pkg::OFF_INT_ACK:      int_d = int_q & ~wdata;
        vmbr_pkg::OFF_STATUS: begin
          if (wdata == '0) begin
            dev_sel_d     = '0;
            drv_sel_d     = '0;
            drv_feat_d[0] = '0;
            drv_feat_d[1] = '0;
            vq_idx_d      = '0;
            queue_size_d  = vmbr_pkg::QUEUE_MAX;
            vq_en_d       = '0;
            desc_d        = '0;
            avail_d       = '0;
            used_d        = '0;
            status_d      = '0;
            int_d         = '0;
          end else begin
            status_d = wdata;
          end
        end
        vmbr_pkg::OFF_DESC_LO:  desc_d[W-1:0] = wdata;
        vmbr_pkg::OFF_DESC_HI:  desc_d[vmbr_pkg::CapW-1:W] = wdata;
        vmbr_pkg::OFF_AVAIL_LO: avail_d[W-1:0] = wdata;
        vmbr_pkg::OFF_AVAIL_HI: avail_d[vmbr_pkg::CapW-1:W] = wdata;
        vmbr_pkg::OFF_USED_LO:  used_d[W-1:0] = wdata;
        vmbr_pkg::OFF_USED_HI:  used_d[vmbr_pkg::CapW-1:W] = wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_sel_q     <= '0;
      drv_sel_q     <= '0;
      drv_feat_q[0] <= '0;
      drv_feat_q[1] <= '0;
      vq_idx_q      <= '0;
      queue_size_q  <= vmbr_pkg::QUEUE_MAX;
      vq_en_q       <= '0;
      desc_q        <= '0;
      avail_q       <= '0;
      used_q        <= '0;
      status_q      <= '0;
      int_q         <= '0;
      cap_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (accept) begin
        dev_sel_q     <= dev_sel_d;
        drv_sel_q     <= drv_sel_d;
        drv_feat_q    <= drv_feat_d;
        vq_idx_q      <= vq_idx_d;
        queue_size_q  <= queue_size_d;
        vq_en_q       <= vq_en_d;
        desc_q        <= desc_d;
        avail_q       <= avail_d;
        used_q        <= used_d;
        status_q      <= status_d;
        int_q         <= int_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= rdata_d;
      irq_q   <= |int_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, irq_q, rdata_q};

  property p_irq_tracks_status;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_q |-> (irq_q == (int_q != '0));
  endproperty
  a_irq_tracks_status: assert property (p_irq_tracks_status)
    else $error("irq flag disagrees with interrupt status");

  property p_nonread_zero;
    @(posedge clk_i) disable iff (!rst_ni)
      (accept && action != vmbr_pkg::ACT_READ) |=> (rdata_q == '0);
  endproperty
  a_nonread_zero: assert property (p_nonread_zero)
    else $error("non-read item returned nonzero data");

  property p_status_clear;
    @(posedge clk_i) disable iff (!rst_ni)
      (accept && action == vmbr_pkg::ACT_WRITE && offset == vmbr_pkg::OFF_STATUS
       && wdata == '0)
      |=> (status_q == '0 && int_q == '0 && queue_size_q == vmbr_pkg::QUEUE_MAX);
  endproperty
  a_status_clear: assert property (p_status_clear)
    else $error("status zero write did not clear run-time state");

  property p_ready_when_empty;
    @(posedge clk_i) disable iff (!rst_ni)
      !out_valid_q |-> s_axis_tready;
  endproperty
  a_ready_when_empty: assert property (p_ready_when_empty)
    else $error("request side stalled with empty response register");

endmodule
